### rtl/adcseq_pkg.sv
// Package: widths, reset values and register map of the ADC sequencer accumulator.
package adcseq_pkg;

  localparam int unsigned ADC_W       = 10;
  localparam int unsigned SUM_W       = 26;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [ADC_W-1:0] PULLDOWN_TARGET_RST = ADC_W'(465);

  localparam int unsigned ROTATION_LENGTH_DEF = 8;

  // Register byte addresses
  localparam logic [APB_ADDR_W-1:0] ADDR_PULLDOWN_TARGET = APB_ADDR_W'(0);

  // Request codes
  typedef enum logic {
    REQ_SAMPLE   = 1'b0,
    REQ_SNAPSHOT = 1'b1
  } req_t;

endpackage

### rtl/adc_sequencer_pulldown_accumulator_unit.sv
// ADC channel sequencer with pulldown control and sample accumulators.
//
// Input channel (in_valid/in_stall): one transfer is either a finished ADC
// conversion (req_type 0, adc_value) or a snapshot request (req_type 1).
// A conversion is credited to the channel in progress (thermistor or
// internal temperature); the next channel is temperature whenever the ratio
// count is a multiple of ROTATION_LENGTH. Counts saturate at 65535 and then
// freeze their sums. A snapshot returns all sums and counts and clears them.
// Output channel (out_valid/out_stall): exactly one result per transfer.
// The result is loaded into the output register when the item is accepted and
// can transfer from there on. Throughput is one item per cycle while the
// output register is free or drains; the state update is a single compare
// and add, and a rotation counter tracks the ratio count modulo
// ROTATION_LENGTH so no divider is needed.
// When the receiver stalls with a result pending, in_stall is raised and the
// held result stays unchanged. Reset clears all sums and counts, sets the
// channel in progress to temperature, the pulldown flag to 0 and the
// pulldown target to 465. The APB port (pready always high) holds the
// pulldown target at byte address 0.
module adc_sequencer_pulldown_accumulator_unit
  import adcseq_pkg::*;
#(
  parameter int unsigned ROTATION_LENGTH = ROTATION_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [ADC_W-1:0]      in_adc_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pulldown_active,
  output logic                  out_next_is_temperature,
  output logic [SUM_W-1:0]      out_thermistor_sum,
  output logic [CNT_W-1:0]      out_thermistor_count,
  output logic [SUM_W-1:0]      out_temperature_sum,
  output logic [CNT_W-1:0]      out_temperature_count,
  output logic [CNT_W-1:0]      out_pulldown_sum,
  output logic [CNT_W-1:0]      out_pulldown_count
);

  localparam int unsigned ROT_W = $clog2(ROTATION_LENGTH);
  localparam logic [ROT_W-1:0] ROT_LAST = ROT_W'(ROTATION_LENGTH - 1);

  // Configuration register
  logic [ADC_W-1:0] target_r;

  // Sequencer state
  logic             conv_temp_r, conv_temp_nxt;
  logic             flag_r, flag_nxt;
  logic [SUM_W-1:0] th_sum_r, th_sum_nxt;
  logic [CNT_W-1:0] th_cnt_r, th_cnt_nxt;
  logic [SUM_W-1:0] te_sum_r, te_sum_nxt;
  logic [CNT_W-1:0] te_cnt_r, te_cnt_nxt;
  logic [CNT_W-1:0] pd_sum_r, pd_sum_nxt;
  logic [CNT_W-1:0] pd_cnt_r, pd_cnt_nxt;
  logic [ROT_W-1:0] rot_r, rot_nxt;

  // Output register
  logic             out_valid_r;
  logic             o_flag_r, o_temp_r;
  logic [SUM_W-1:0] o_th_sum_r, o_te_sum_r;
  logic [CNT_W-1:0] o_th_cnt_r, o_te_cnt_r, o_pd_sum_r, o_pd_cnt_r;

  logic in_xfer, out_free;

  // Handshake: take a new item whenever the output register is free or drains
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free;
  assign in_xfer  = in_valid && out_free;

  // APB access
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_PULLDOWN_TARGET) begin
      prdata = APB_DATA_W'(target_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= PULLDOWN_TARGET_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ADDR_PULLDOWN_TARGET) begin
      target_r <= pwdata[ADC_W-1:0];
    end
  end

  // Next state for one sample or snapshot
  always_comb begin
    conv_temp_nxt = conv_temp_r;
    flag_nxt      = flag_r;
    th_sum_nxt    = th_sum_r;
    th_cnt_nxt    = th_cnt_r;
    te_sum_nxt    = te_sum_r;
    te_cnt_nxt    = te_cnt_r;
    pd_sum_nxt    = pd_sum_r;
    pd_cnt_nxt    = pd_cnt_r;
    rot_nxt       = rot_r;
    if (req_t'(in_req_type) == REQ_SNAPSHOT) begin
      th_sum_nxt = '0;
      th_cnt_nxt = '0;
      te_sum_nxt = '0;
      te_cnt_nxt = '0;
      pd_sum_nxt = '0;
      pd_cnt_nxt = '0;
      rot_nxt    = '0;
    end else begin
      // channel choice uses the ratio count before this sample
      conv_temp_nxt = (rot_r == '0);
      if (conv_temp_r) begin
        if (te_cnt_r != CNT_MAX) begin
          te_sum_nxt = te_sum_r + SUM_W'(in_adc_value);
          te_cnt_nxt = te_cnt_r + CNT_W'(1);
        end
      end else begin
        flag_nxt = (in_adc_value > target_r);
        if (th_cnt_r != CNT_MAX) begin
          th_sum_nxt = th_sum_r + SUM_W'(in_adc_value);
          th_cnt_nxt = th_cnt_r + CNT_W'(1);
        end
      end
      // ratio accumulator; rotation counter follows the ratio count
      if (pd_cnt_r != CNT_MAX) begin
        pd_sum_nxt = pd_sum_r + CNT_W'(flag_nxt);
        pd_cnt_nxt = pd_cnt_r + CNT_W'(1);
        rot_nxt    = (rot_r == ROT_LAST) ? '0 : rot_r + ROT_W'(1);
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_temp_r <= 1'b1;
      flag_r      <= 1'b0;
      th_sum_r    <= '0;
      th_cnt_r    <= '0;
      te_sum_r    <= '0;
      te_cnt_r    <= '0;
      pd_sum_r    <= '0;
      pd_cnt_r    <= '0;
      rot_r       <= '0;
    end else if (in_xfer) begin
      conv_temp_r <= conv_temp_nxt;
      flag_r      <= flag_nxt;
      th_sum_r    <= th_sum_nxt;
      th_cnt_r    <= th_cnt_nxt;
      te_sum_r    <= te_sum_nxt;
      te_cnt_r    <= te_cnt_nxt;
      pd_sum_r    <= pd_sum_nxt;
      pd_cnt_r    <= pd_cnt_nxt;
      rot_r       <= rot_nxt;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid;
    end
  end

  // Output payload: snapshot reports values before the clear
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      o_flag_r <= flag_nxt;
      o_temp_r <= conv_temp_nxt;
      if (req_t'(in_req_type) == REQ_SNAPSHOT) begin
        o_th_sum_r <= th_sum_r;
        o_th_cnt_r <= th_cnt_r;
        o_te_sum_r <= te_sum_r;
        o_te_cnt_r <= te_cnt_r;
        o_pd_sum_r <= pd_sum_r;
        o_pd_cnt_r <= pd_cnt_r;
      end else begin
        o_th_sum_r <= th_sum_nxt;
        o_th_cnt_r <= th_cnt_nxt;
        o_te_sum_r <= te_sum_nxt;
        o_te_cnt_r <= te_cnt_nxt;
        o_pd_sum_r <= pd_sum_nxt;
        o_pd_cnt_r <= pd_cnt_nxt;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_pulldown_active     = o_flag_r;
  assign out_next_is_temperature = o_temp_r;
  assign out_thermistor_sum      = o_th_sum_r;
  assign out_thermistor_count    = o_th_cnt_r;
  assign out_temperature_sum     = o_te_sum_r;
  assign out_temperature_count   = o_te_cnt_r;
  assign out_pulldown_sum        = o_pd_sum_r;
  assign out_pulldown_count      = o_pd_cnt_r;

  // Assertions

  // an accepted item always shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted item produced no result");

  // a pending result that is not taken blocks the input side
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !in_xfer)
    else $error("item accepted while result stalled");

  // rotation counter stays inside the rotation
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    rot_r <= ROT_LAST)
    else $error("rotation counter out of range");

  // pulldown hits never exceed the samples counted
  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pd_sum_r <= pd_cnt_r)
    else $error("pulldown sum above pulldown count");

  // a snapshot leaves all counts cleared
  a_snapshot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req_type) |=>
      (th_cnt_r == '0 && te_cnt_r == '0 && pd_cnt_r == '0 && rot_r == '0))
    else $error("snapshot did not clear counts");

endmodule
